@@ rtl/core/text_cell_rasterizer_unit_macros.svh @@
// ----------------------------------------------------------------------------
// text cell rasterizer assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef TEXT_CELL_RASTERIZER_UNIT_MACROS_SVH
`define TEXT_CELL_RASTERIZER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define TCR_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("tcr assertion failed");

// condition must never be true out of reset
`define TCR_ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("tcr forbidden condition seen");

`else

`define TCR_ASSERT(label, clk, rstn, prop)
`define TCR_ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

@@ rtl/core/tcr_pkg.sv @@
// ----------------------------------------------------------------------------
// tcr_pkg
// types, constants and microcode table of the text cell rasterizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcr_pkg;

  localparam int unsigned STEP_W = 3;

  localparam logic [11:0] CURSOR_MAX   = 12'd4095;
  localparam logic [20:0] CODE_NEWLINE = 21'd10;
  localparam logic [20:0] CODE_RETURN  = 21'd13;
  localparam logic [20:0] CODE_TAB     = 21'd9;
  localparam logic [7:0]  COVER_SET    = 8'hFF;
  localparam logic [7:0]  COVER_CLEAR  = 8'h00;

  // configuration register indexes
  localparam logic [1:0] REG_CELL_WIDTH  = 2'd0;
  localparam logic [1:0] REG_CELL_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ROW_STRIDE  = 2'd2;

  // sequencer steps
  localparam logic [STEP_W-1:0] S_IDLE    = 3'd0;
  localparam logic [STEP_W-1:0] S_CLASS   = 3'd1;
  localparam logic [STEP_W-1:0] S_BASE    = 3'd2;
  localparam logic [STEP_W-1:0] S_PIX     = 3'd3;
  localparam logic [STEP_W-1:0] S_ADVANCE = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLASS,
    OP_BASE,
    OP_PIX,
    OP_ADVANCE
  } op_e;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_CTRL,
    COND_CELL_MORE
  } cond_e;

  typedef struct packed {
    op_e               op;
    logic              wait_in;
    logic              wait_out;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    op_e  op;
    logic go;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic is_ctrl;
    logic cell_end;
  } stat_t;

  typedef struct packed {
    logic [3:0]  cell_w;
    logic [3:0]  cell_h;
    logic [15:0] stride;
  } cfg_t;

  function automatic ucode_t tcr_ucode(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{op: OP_NONE, wait_in: 1'b0, wait_out: 1'b0, cond: COND_ALWAYS, target: S_IDLE};
    case (step)
      S_IDLE: begin
        w = '{op: OP_LOAD, wait_in: 1'b1, wait_out: 1'b0, cond: COND_NEVER, target: S_IDLE};
      end
      S_CLASS: begin
        w = '{op: OP_CLASS, wait_in: 1'b0, wait_out: 1'b0, cond: COND_CTRL, target: S_IDLE};
      end
      S_BASE: begin
        w = '{op: OP_BASE, wait_in: 1'b0, wait_out: 1'b0, cond: COND_NEVER, target: S_IDLE};
      end
      S_PIX: begin
        w = '{op: OP_PIX, wait_in: 1'b0, wait_out: 1'b1, cond: COND_CELL_MORE,
              target: S_PIX};
      end
      S_ADVANCE: begin
        w = '{op: OP_ADVANCE, wait_in: 1'b0, wait_out: 1'b0, cond: COND_ALWAYS,
              target: S_IDLE};
      end
      default: begin
        w = '{op: OP_NONE, wait_in: 1'b0, wait_out: 1'b0, cond: COND_ALWAYS, target: S_IDLE};
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/tcr_in_if.sv @@
// ----------------------------------------------------------------------------
// tcr_in_if
// character word channel: code point and glyph bitmap
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tcr_in_if;
  logic        valid;
  logic        ready;
  logic        first_of_text;
  logic [20:0] code_point;
  logic [63:0] glyph_bits;

  modport source (output valid, output first_of_text, output code_point,
                  output glyph_bits, input ready);
  modport sink (input valid, input first_of_text, input code_point,
                input glyph_bits, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tcr_out_if.sv @@
// ----------------------------------------------------------------------------
// tcr_out_if
// pixel word channel: buffer address and coverage byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tcr_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_address;
  logic [7:0]  pixel_value;
  logic        last_pixel;

  modport source (output valid, output pixel_address, output pixel_value,
                  output last_pixel, input ready);
  modport sink (input valid, input pixel_address, input pixel_value,
                input last_pixel, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tcr_sequencer.sv @@
// ----------------------------------------------------------------------------
// tcr_sequencer
// step counter over the microcode table with conditional jumps and waits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "text_cell_rasterizer_unit_macros.svh"

module tcr_sequencer
  import tcr_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire stat_t stat_i,
  output ctrl_t      ctrl_o
);

  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            word;
  logic              stall;
  logic              jump;

  assign word = tcr_ucode(step_q);

  always_comb begin
    stall = (word.wait_in && !stat_i.in_valid) || (word.wait_out && !stat_i.out_free);
    case (word.cond)
      COND_NEVER:     jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_CTRL:      jump = stat_i.is_ctrl;
      COND_CELL_MORE: jump = !stat_i.cell_end;
      default:        jump = 1'b0;
    endcase
    if (stall) begin
      step_d = step_q;
    end else if (jump) begin
      step_d = word.target;
    end else begin
      step_d = step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o.op = word.op;
  assign ctrl_o.go = !stall;

  `TCR_ASSERT(a_load_then_class, clk_i, rst_ni,
    (step_q == S_IDLE && !stall) |=> (step_q == S_CLASS))
  `TCR_ASSERT_NEVER(a_step_in_range, clk_i, rst_ni, step_q > S_ADVANCE)

endmodule

`default_nettype wire

@@ rtl/core/tcr_datapath.sv @@
// ----------------------------------------------------------------------------
// tcr_datapath
// cursor, cell address generation and pixel output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "text_cell_rasterizer_unit_macros.svh"

module tcr_datapath
  import tcr_pkg::*;
#(
  parameter int unsigned TAB_COLUMNS  = 8,
  parameter int unsigned ADDRESS_BITS = 24
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire ctrl_t ctrl_i,
  output stat_t      stat_o,
  tcr_in_if.sink     text_i,
  tcr_out_if.source  pixel_o
);

  // column / TAB_COLUMNS by reciprocal multiplication, exact for 12-bit columns
  localparam int unsigned TAB_SHIFT = 20;
  localparam logic [20:0] TAB_RECIP =
    21'(((32'd1 << TAB_SHIFT) + TAB_COLUMNS - 32'd1) / TAB_COLUMNS);

  logic [11:0]             col_q, row_q;
  logic [2:0]              x_q, y_q;
  logic                    out_valid_q;
  logic [20:0]             code_q;
  logic [63:0]             glyph_q;
  logic [14:0]             rowh_q;
  logic [ADDRESS_BITS-1:0] base_q;
  logic [23:0]             out_addr_q;
  logic [7:0]              out_value_q;
  logic                    out_last_q;

  logic [2:0]  wm1, hm1;
  logic        last_x, last_y, cell_end;
  logic        out_free, emit;
  logic        is_nl, is_ret, is_tab;
  logic [11:0] row_inc, col_inc, tab_col;
  logic [31:0] tab_prod;
  logic [11:0] tab_quo;
  logic [12:0] tab_sum;
  logic [30:0] row_prod;
  logic [31:0] base_full;
  logic        pix_bit;

  always_comb begin
    wm1       = 3'(cfg_i.cell_w - 4'd1);
    hm1       = 3'(cfg_i.cell_h - 4'd1);
    last_x    = (x_q == wm1);
    last_y    = (y_q == hm1);
    cell_end  = last_x && last_y;
    out_free  = !out_valid_q || pixel_o.ready;
    emit      = ctrl_i.go && (ctrl_i.op == OP_PIX);
    is_nl     = (code_q == CODE_NEWLINE);
    is_ret    = (code_q == CODE_RETURN);
    is_tab    = (code_q == CODE_TAB);
    row_inc   = (row_q == CURSOR_MAX) ? row_q : row_q + 12'd1;
    col_inc   = (col_q == CURSOR_MAX) ? col_q : col_q + 12'd1;
    tab_prod  = 32'(col_q) * 32'(TAB_RECIP);
    tab_quo   = tab_prod[TAB_SHIFT +: 12];
    tab_sum   = 13'((19'(tab_quo) + 19'd1) * 19'(TAB_COLUMNS));
    tab_col   = (tab_sum > 13'(CURSOR_MAX)) ? CURSOR_MAX : tab_sum[11:0];
    row_prod  = 31'(rowh_q) * 31'(cfg_i.stride);
    base_full = 32'(row_prod) + 32'(16'(col_q) * 16'(cfg_i.cell_w));
    // row 0 sits in the top byte, msb leftmost
    pix_bit   = glyph_q[{~y_q, ~x_q}];
  end

  assign stat_o.in_valid = text_i.valid;
  assign stat_o.out_free = out_free;
  assign stat_o.is_ctrl  = is_nl || is_ret || is_tab;
  assign stat_o.cell_end = cell_end;

  assign text_i.ready = (ctrl_i.op == OP_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pixel_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (ctrl_i.go) begin
        case (ctrl_i.op)
          OP_LOAD: begin
            if (text_i.first_of_text) begin
              col_q <= '0;
              row_q <= '0;
            end
          end
          OP_CLASS: begin
            if (is_nl) begin
              col_q <= '0;
              row_q <= row_inc;
            end else if (is_tab) begin
              col_q <= tab_col;
            end
          end
          OP_BASE: begin
            x_q <= '0;
            y_q <= '0;
          end
          OP_PIX: begin
            if (last_x) begin
              x_q <= '0;
              y_q <= last_y ? 3'd0 : y_q + 3'd1;
            end else begin
              x_q <= x_q + 3'd1;
            end
          end
          OP_ADVANCE: begin
            col_q <= col_inc;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.go) begin
      case (ctrl_i.op)
        OP_LOAD: begin
          code_q  <= text_i.code_point;
          glyph_q <= text_i.glyph_bits;
        end
        OP_CLASS: begin
          rowh_q <= 15'(16'(row_q) * 16'(cfg_i.cell_h));
        end
        OP_BASE: begin
          base_q <= base_full[ADDRESS_BITS-1:0];
        end
        OP_PIX: begin
          out_addr_q  <= 24'(base_q + ADDRESS_BITS'(x_q));
          out_value_q <= pix_bit ? COVER_SET : COVER_CLEAR;
          out_last_q  <= cell_end;
          if (last_x) begin
            base_q <= base_q + ADDRESS_BITS'(cfg_i.stride);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign pixel_o.valid         = out_valid_q;
  assign pixel_o.pixel_address = out_addr_q;
  assign pixel_o.pixel_value   = out_value_q;
  assign pixel_o.last_pixel    = out_last_q;

  `TCR_ASSERT(a_cell_wraps, clk_i, rst_ni,
    (emit && cell_end) |=> (x_q == 3'd0 && y_q == 3'd0))
  `TCR_ASSERT_NEVER(a_emit_into_full, clk_i, rst_ni, emit && !out_free)
  `TCR_ASSERT(a_column_advance, clk_i, rst_ni,
    (ctrl_i.go && ctrl_i.op == OP_ADVANCE)
      |=> (col_q == $past(col_q) + 12'd1 || col_q == CURSOR_MAX))

endmodule

`default_nettype wire

@@ rtl/core/text_cell_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// text_cell_rasterizer_unit
// monospace bitmap font character generator with a text cursor
// ----------------------------------------------------------------------------
// text_i takes one word per character: code point, glyph bitmap and a flag
// that clears the cursor to column 0 row 0 first. pixel_o gives one word per
// cell pixel: buffer address, coverage byte 255 or 0, and a flag on the last
// pixel of the cell. newline, carriage return and tab give no pixel words.
// cell_width, cell_height and row_stride are written through cfg_we_i,
// cfg_index_i and cfg_data_i; the user must write them only while the block
// is idle, the block itself does not enforce this. only cfg_data_i[3:0] is
// kept for the cell size: zero acts as 1 and values above 8 act as 8.
// a drawn character passes the load, classify, base address, pixel and
// cursor advance steps; the microcode sequencer emits one pixel per cycle
// from the pixel step while the receiver takes them. a control character
// only passes load and classify. the first pixel word follows the base step.
// the pixel output register lets the next character word be taken while the
// last pixel still waits; a stalled receiver holds the sequencer in the pixel
// step. reset clears the cursor, sets the registers to 8, 8 and 640 and
// leaves the output channel empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_cell_rasterizer_unit
  import tcr_pkg::*;
#(
  parameter int unsigned TAB_COLUMNS  = 8,
  parameter int unsigned ADDRESS_BITS = 24
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [15:0] cfg_data_i,
  tcr_in_if.sink      text_i,
  tcr_out_if.source   pixel_o
);

  logic [3:0]  cell_w_q, cell_h_q;
  logic [15:0] stride_q;
  cfg_t        cfg;
  ctrl_t       ctrl;
  stat_t       stat;

  function automatic logic [3:0] clamp_cell(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (v == 4'd0) begin
      r = 4'd1;
    end else if (v > 4'd8) begin
      r = 4'd8;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_w_q <= 4'd8;
      cell_h_q <= 4'd8;
      stride_q <= 16'd640;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CELL_WIDTH:  cell_w_q <= cfg_data_i[3:0];
        REG_CELL_HEIGHT: cell_h_q <= cfg_data_i[3:0];
        REG_ROW_STRIDE:  stride_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg.cell_w = clamp_cell(cell_w_q);
  assign cfg.cell_h = clamp_cell(cell_h_q);
  assign cfg.stride = stride_q;

  tcr_sequencer u_sequencer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  tcr_datapath #(
    .TAB_COLUMNS  (TAB_COLUMNS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .ctrl_i  (ctrl),
    .stat_o  (stat),
    .text_i  (text_i),
    .pixel_o (pixel_o)
  );

endmodule

`default_nettype wire
